@@ sv/lzwdd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwdd_pkg
// shared types and constants of the lzw decode dictionary unit
// ----------------------------------------------------------------------------
package lzwdd_pkg;

	localparam int TOTAL_CODES = 4096;
	localparam int CODE_W      = 12;
	localparam int LEN_W       = 13;
	localparam int SYM_W       = 8;
	localparam int FUNC_W      = 2;
	localparam int BASE_W      = 9;
	localparam int SLOT_COUNT  = TOTAL_CODES - 256;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int BUF_AW      = $clog2(TOTAL_CODES);
	localparam int DICT_W      = CODE_W + SYM_W;

	localparam logic [FUNC_W-1:0] FUNC_EXPAND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

	// register index, taken from paddr[2]
	localparam logic REG_FIRST_FREE = 1'b0;

	localparam logic [BASE_W-1:0] LITERAL_COUNT = 9'd256;
	localparam logic [BASE_W-1:0] BASE_RESET    = 9'd257;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} slot_t;

	typedef struct packed {
		logic              dict_we;
		logic [SLOT_W-1:0] dict_waddr;
		logic [DICT_W-1:0] dict_wdata;
		logic [SLOT_W-1:0] dict_raddr;
		logic              buf_we;
		logic [BUF_AW-1:0] buf_waddr;
		logic [SYM_W-1:0]  buf_wdata;
		logic [BUF_AW-1:0] buf_raddr;
	} mem_req_t;

endpackage

@@ sv/lzwdd_ram.sv @@
// ----------------------------------------------------------------------------
// lzwdd_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lzwdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/lzwdd_slot_unit.sv @@
// ----------------------------------------------------------------------------
// lzwdd_slot_unit
// shared subtractor mapping a code to its dictionary slot
// ----------------------------------------------------------------------------
module lzwdd_slot_unit (
	input  logic [lzwdd_pkg::CODE_W-1:0] code,
	input  logic [lzwdd_pkg::BASE_W-1:0] base,
	output lzwdd_pkg::slot_t             res
);

	logic [lzwdd_pkg::BASE_W-1:0] eff_base;
	logic [lzwdd_pkg::LEN_W-1:0]  diff;
	logic                         below_top;

	always_comb begin
		eff_base  = (base < lzwdd_pkg::LITERAL_COUNT) ? lzwdd_pkg::LITERAL_COUNT : base;
		diff      = {1'b0, code} - {{(lzwdd_pkg::LEN_W - lzwdd_pkg::BASE_W){1'b0}}, eff_base};
		below_top = {1'b0, code} < lzwdd_pkg::LEN_W'(lzwdd_pkg::TOTAL_CODES);
		res.hit   = !diff[lzwdd_pkg::LEN_W-1] && below_top;
		res.slot  = diff[lzwdd_pkg::SLOT_W-1:0];
	end

endmodule

@@ sv/lzwdd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzwdd_ctrl
// sequencer walking prefix chains, filling the string buffer, storing entries
// ----------------------------------------------------------------------------
module lzwdd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lzwdd_pkg::FUNC_W-1:0]  in_func,
	input  logic [lzwdd_pkg::CODE_W-1:0]  in_cur,
	input  logic [lzwdd_pkg::CODE_W-1:0]  in_prev,
	input  logic [lzwdd_pkg::CODE_W-1:0]  in_next,
	input  logic [lzwdd_pkg::CODE_W-1:0]  in_ridx,
	input  logic [lzwdd_pkg::BASE_W-1:0]  base,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lzwdd_pkg::LEN_W-1:0]   out_len,
	output logic [lzwdd_pkg::SYM_W-1:0]   out_first,
	output logic [lzwdd_pkg::SYM_W-1:0]   out_byte,
	output lzwdd_pkg::mem_req_t           mem,
	input  logic [lzwdd_pkg::DICT_W-1:0]  dict_rdata,
	input  logic [lzwdd_pkg::SYM_W-1:0]   buf_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FETCH,
		ST_FINISH,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_OUT
	} state_t;

	state_t                        state_q;
	logic [lzwdd_pkg::FUNC_W-1:0]  func_q;
	logic [lzwdd_pkg::CODE_W-1:0]  code_q;
	logic [lzwdd_pkg::CODE_W-1:0]  prev_q;
	logic [lzwdd_pkg::CODE_W-1:0]  next_q;
	logic [lzwdd_pkg::CODE_W-1:0]  ridx_q;
	logic [lzwdd_pkg::LEN_W-1:0]   len_q;
	logic [lzwdd_pkg::LEN_W-1:0]   blen_q;
	logic [lzwdd_pkg::SYM_W-1:0]   first_q;
	logic                          kwk_q;

	logic [lzwdd_pkg::CODE_W-1:0]  operand;
	lzwdd_pkg::slot_t              slot;
	logic                          walk_on;
	logic                          in_kwk;

	// one subtractor serves the walk and the entry store
	assign operand = (state_q == ST_FINISH) ? next_q : code_q;

	lzwdd_slot_unit u_slot (
		.code (operand),
		.base (base),
		.res  (slot)
	);

	assign walk_on   = slot.hit && (len_q < lzwdd_pkg::LEN_W'(lzwdd_pkg::TOTAL_CODES - 1));
	assign in_kwk    = (in_func == lzwdd_pkg::FUNC_ADD) && (in_cur == in_next);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		mem            = '0;
		mem.dict_raddr = slot.slot;
		mem.buf_raddr  = ridx_q;
		mem.dict_waddr = slot.slot;
		mem.dict_wdata = {prev_q, first_q};
		mem.buf_waddr  = len_q[lzwdd_pkg::BUF_AW-1:0];
		unique case (state_q)
			ST_CHECK: begin
				mem.buf_we    = !walk_on;
				mem.buf_wdata = code_q[lzwdd_pkg::SYM_W-1:0];
			end
			ST_FETCH: begin
				mem.buf_we    = 1'b1;
				mem.buf_wdata = dict_rdata[lzwdd_pkg::SYM_W-1:0];
			end
			ST_FINISH: begin
				// repeated first symbol goes to the front of the buffer
				mem.buf_we    = kwk_q;
				mem.buf_waddr = '0;
				mem.buf_wdata = first_q;
				mem.dict_we   = (func_q == lzwdd_pkg::FUNC_ADD) && slot.hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			blen_q    <= '0;
			func_q    <= lzwdd_pkg::FUNC_EXPAND;
			kwk_q     <= 1'b0;
			len_q     <= '0;
			code_q    <= '0;
			prev_q    <= '0;
			next_q    <= '0;
			ridx_q    <= '0;
			first_q   <= '0;
			out_len   <= '0;
			out_first <= '0;
			out_byte  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= in_func;
						prev_q <= in_prev;
						next_q <= in_next;
						ridx_q <= in_ridx;
						kwk_q  <= in_kwk;
						code_q <= in_kwk ? in_prev : in_cur;
						len_q  <= in_kwk ? lzwdd_pkg::LEN_W'(1) : '0;
						unique case (in_func)
							lzwdd_pkg::FUNC_EXPAND, lzwdd_pkg::FUNC_ADD: begin
								state_q <= ST_CHECK;
							end
							lzwdd_pkg::FUNC_READ: begin
								state_q <= ST_RD_ADDR;
							end
							default: begin
								out_len   <= blen_q;
								out_first <= '0;
								out_byte  <= '0;
								state_q   <= ST_OUT;
							end
						endcase
					end
				end
				ST_CHECK: begin
					if (walk_on) begin
						state_q <= ST_FETCH;
					end else begin
						first_q <= code_q[lzwdd_pkg::SYM_W-1:0];
						len_q   <= len_q + 1'b1;
						state_q <= ST_FINISH;
					end
				end
				ST_FETCH: begin
					len_q   <= len_q + 1'b1;
					code_q  <= dict_rdata[lzwdd_pkg::DICT_W-1:lzwdd_pkg::SYM_W];
					state_q <= ST_CHECK;
				end
				ST_FINISH: begin
					blen_q    <= len_q;
					out_len   <= len_q;
					out_first <= first_q;
					out_byte  <= '0;
					state_q   <= ST_OUT;
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					out_len   <= blen_q;
					out_first <= '0;
					out_byte  <= buf_rdata;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while a result is pending");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= lzwdd_pkg::LEN_W'(lzwdd_pkg::TOTAL_CODES))
		else $error("string length beyond buffer size");

	a_store_func: assert property (@(posedge clk) disable iff (!arst_n)
		mem.dict_we |-> (func_q == lzwdd_pkg::FUNC_ADD) && (state_q == ST_FINISH))
		else $error("dictionary written outside an add request");

	a_return_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("not ready after result taken");

endmodule

@@ sv/lzw_decode_dictionary_unit.sv @@
// ----------------------------------------------------------------------------
// lzw_decode_dictionary_unit
// lzw decoder dictionary with prefix chain walk and reversed string buffer
// ----------------------------------------------------------------------------
// One request at a time. An expand request (func 0 or 1) visits the check and
// fetch states once per dictionary step of the string, then check, finish and
// the output state; each step waits on the registered read of the dictionary
// ram. A buffer read (func 2) passes the read address, read data and output
// states, and func 3 goes straight to the output state.
// s_tready is high only while no request is in progress or pending on the
// output; the result is held on m_tdata until taken. first_free_code may be
// written over the apb port only while the unit is idle.
module lzw_decode_dictionary_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cur_code, prev_code, free_slot, read_index
	input  logic [47:0] s_tdata,
	// func
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// string_length, first_sym, read_byte, zero fill
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [lzwdd_pkg::BASE_W-1:0] first_free_code_q;
	lzwdd_pkg::mem_req_t          mem;
	logic [lzwdd_pkg::DICT_W-1:0] dict_rdata;
	logic [lzwdd_pkg::SYM_W-1:0]  buf_rdata;
	logic [lzwdd_pkg::LEN_W-1:0]  out_len;
	logic [lzwdd_pkg::SYM_W-1:0]  out_first;
	logic [lzwdd_pkg::SYM_W-1:0]  out_byte;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == lzwdd_pkg::REG_FIRST_FREE) ? {23'd0, first_free_code_q}
		: 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_free_code_q <= lzwdd_pkg::BASE_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == lzwdd_pkg::REG_FIRST_FREE)) begin
			first_free_code_q <= pwdata[lzwdd_pkg::BASE_W-1:0];
		end
	end

	lzwdd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_func    (s_tuser),
		.in_cur     (s_tdata[11:0]),
		.in_prev    (s_tdata[23:12]),
		.in_next    (s_tdata[35:24]),
		.in_ridx    (s_tdata[47:36]),
		.base       (first_free_code_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_len    (out_len),
		.out_first  (out_first),
		.out_byte   (out_byte),
		.mem        (mem),
		.dict_rdata (dict_rdata),
		.buf_rdata  (buf_rdata)
	);

	lzwdd_ram #(
		.WIDTH (lzwdd_pkg::DICT_W),
		.DEPTH (lzwdd_pkg::SLOT_COUNT)
	) u_dict_ram (
		.clk   (clk),
		.we    (mem.dict_we),
		.waddr (mem.dict_waddr),
		.wdata (mem.dict_wdata),
		.raddr (mem.dict_raddr),
		.rdata (dict_rdata)
	);

	lzwdd_ram #(
		.WIDTH (lzwdd_pkg::SYM_W),
		.DEPTH (lzwdd_pkg::TOTAL_CODES)
	) u_buf_ram (
		.clk   (clk),
		.we    (mem.buf_we),
		.waddr (mem.buf_waddr),
		.wdata (mem.buf_wdata),
		.raddr (mem.buf_raddr),
		.rdata (buf_rdata)
	);

	assign m_tdata = {3'd0, out_byte, out_first, out_len};

endmodule
